/* sv/sfd_pkg.sv */
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the SLIP frame decoder: framing byte codes,
// the width of the length/count path, and the store write request.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

  // SLIP framing codes
  localparam logic [7:0] SlipEnd    = 8'hC0;
  localparam logic [7:0] SlipEsc    = 8'hDB;
  localparam logic [7:0] SlipEscEnd = 8'hDC;
  localparam logic [7:0] SlipEscEsc = 8'hDD;

  // Command codes
  localparam logic CmdFeed = 1'b0;
  localparam logic CmdRead = 1'b1;

  // Frame length / byte count width (limit register is 11 bits)
  localparam int unsigned CountW = 11;
  localparam int unsigned IndexW = 10;

  // Reset value of the length limit
  localparam logic [CountW-1:0] MaxLenReset = 11'd1024;

  // One write into the frame store
  typedef struct packed {
    logic              en;
    logic [CountW-1:0] addr;
    logic [7:0]        data;
  } wr_req_t;

  // Per-item decode result
  typedef struct packed {
    logic              done;
    logic [CountW-1:0] length;
  } dec_res_t;

endpackage

`default_nettype wire

/* sv/sfd_store.sv */
// ----------------------------------------------------------------------------
// sfd_store
// Frame body store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_store #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire sfd_pkg::wr_req_t             wr,
  input  wire logic                         rd_en,
  input  wire logic [sfd_pkg::IndexW-1:0]   rd_addr,
  output logic      [7:0]                   rd_data
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]       mem [DEPTH];
  logic [31:0]      wa_ext;
  logic [31:0]      ra_ext;
  logic [AddrW-1:0] wa;
  logic [AddrW-1:0] ra;

  // Resize addresses to the store depth; reads past the depth are masked
  // by the caller, writes never go past it.
  assign wa_ext = 32'(wr.addr);
  assign ra_ext = 32'(rd_addr);
  assign wa     = wa_ext[AddrW-1:0];
  assign ra     = ra_ext[AddrW-1:0];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wa] <= wr.data;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[ra];
    end
  end

endmodule

`default_nettype wire

/* sv/sfd_decode.sv */
// ----------------------------------------------------------------------------
// sfd_decode
// SLIP byte decoder: framing state, escape handling, length limit and the
// store write request for one fed byte per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_decode #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         feed,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [sfd_pkg::CountW-1:0]   max_len,
  output sfd_pkg::dec_res_t                 res,
  output sfd_pkg::wr_req_t                  wr,
  output logic      [sfd_pkg::CountW-1:0]   count
);

  // Hard cap on the limit: the store depth, or what the count can hold
  localparam int unsigned CountMax = (1 << sfd_pkg::CountW) - 1;
  localparam int unsigned LimCap   = (STORE_DEPTH > CountMax) ? CountMax : STORE_DEPTH;
  localparam logic [sfd_pkg::CountW-1:0] LimCapW = sfd_pkg::CountW'(LimCap);

  logic                         inside_frame, inside_frame_next;
  logic                         escape_pending, escape_pending_next;
  logic                         frame_bad, frame_bad_next;
  logic                         done_pending, done_pending_next;
  logic [sfd_pkg::CountW-1:0]   stored_count, stored_count_next;
  logic [sfd_pkg::CountW-1:0]   count_base;
  logic [sfd_pkg::CountW-1:0]   limit;
  logic                         store_byte;
  logic [7:0]                   byte_val;
  logic                         done;

  // Effective limit and count after a completed frame is released
  assign limit      = (max_len > LimCapW) ? LimCapW : max_len;
  assign count_base = done_pending ? '0 : stored_count;

  // Next-state logic for one fed byte
  always_comb begin
    inside_frame_next   = inside_frame;
    escape_pending_next = escape_pending;
    frame_bad_next      = frame_bad;
    done_pending_next   = done_pending;
    stored_count_next   = stored_count;
    store_byte          = 1'b0;
    byte_val            = rx_byte;
    done                = 1'b0;
    wr                  = '0;

    if (feed) begin
      done_pending_next = 1'b0;
      stored_count_next = count_base;
      if (rx_byte == sfd_pkg::SlipEnd) begin
        if (inside_frame && (count_base != '0) && !frame_bad) begin
          // good frame closes; body stays readable until the next feed
          done_pending_next   = 1'b1;
          escape_pending_next = 1'b0;
          done                = 1'b1;
        end else begin
          // (re)open a frame
          inside_frame_next   = 1'b1;
          stored_count_next   = '0;
          escape_pending_next = 1'b0;
          frame_bad_next      = 1'b0;
        end
      end else if (inside_frame) begin
        if (escape_pending) begin
          escape_pending_next = 1'b0;
          priority if (rx_byte == sfd_pkg::SlipEscEnd) begin
            byte_val   = sfd_pkg::SlipEnd;
            store_byte = 1'b1;
          end else if (rx_byte == sfd_pkg::SlipEscEsc) begin
            byte_val   = sfd_pkg::SlipEsc;
            store_byte = 1'b1;
          end else begin
            frame_bad_next = 1'b1;
          end
        end else if (rx_byte == sfd_pkg::SlipEsc) begin
          escape_pending_next = 1'b1;
        end else begin
          store_byte = 1'b1;
        end

        // Store the body byte, or mark the frame bad when full
        if (store_byte) begin
          if (count_base >= limit) begin
            frame_bad_next = 1'b1;
          end else begin
            wr.en             = 1'b1;
            wr.addr           = count_base;
            wr.data           = byte_val;
            stored_count_next = count_base + 1'b1;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_frame   <= 1'b0;
      escape_pending <= 1'b0;
      frame_bad      <= 1'b0;
      done_pending   <= 1'b0;
      stored_count   <= '0;
    end else begin
      inside_frame   <= inside_frame_next;
      escape_pending <= escape_pending_next;
      frame_bad      <= frame_bad_next;
      done_pending   <= done_pending_next;
      stored_count   <= stored_count_next;
    end
  end

  assign res.done   = done;
  assign res.length = stored_count_next;
  assign count      = stored_count;

endmodule

`default_nettype wire

/* sv/slip_frame_decoder.sv */
// ----------------------------------------------------------------------------
// slip_frame_decoder
// SLIP (END/ESC framing) receive decoder with a frame body store and a read
// command that returns stored bytes.
//
//   Channel  Dir  Handshake             Payload
//   in       in   in_valid/in_ready     command, rx_byte, read_index
//   out      out  out_valid/out_ready   frame_done, frame_length, read_data
//   cfg      in   cfg_valid/cfg_ready   cfg_data (max_frame_length)
//
// One item per cycle unless the output stalls; each result appears in the
// cycle after its transfer, from output registers and the store read port.
// in_ready drops only while a result is held and out_ready is low.
// cfg_ready is always high; the limit register takes effect on the next item.
// Reset (rst, synchronous) clears framing state and out_valid and loads the
// reset limit; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module slip_frame_decoder #(
  parameter int unsigned STORE_DEPTH = 1024
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // input items
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         command,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [sfd_pkg::IndexW-1:0]   read_index,
  // results
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              frame_done,
  output logic      [sfd_pkg::CountW-1:0]   frame_length,
  output logic      [7:0]                   read_data,
  // configuration
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [sfd_pkg::CountW-1:0]   cfg_data
);

  logic                         in_xfer;
  logic                         feed;
  logic [sfd_pkg::CountW-1:0]   max_frame_length;
  logic [sfd_pkg::CountW-1:0]   count;
  logic                         read_hit;
  logic                         read_hit_q;
  logic [7:0]                   store_q;
  sfd_pkg::dec_res_t            res;
  sfd_pkg::wr_req_t             wr;

  // Handshake
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign feed      = in_xfer && (command == sfd_pkg::CmdFeed);
  assign cfg_ready = 1'b1;

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= sfd_pkg::MaxLenReset;
    end else if (cfg_valid && cfg_ready) begin
      max_frame_length <= cfg_data;
    end
  end

  // Decoder
  sfd_decode #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_decode (
    .clk     (clk),
    .rst     (rst),
    .feed    (feed),
    .rx_byte (rx_byte),
    .max_len (max_frame_length),
    .res     (res),
    .wr      (wr),
    .count   (count)
  );

  // Reads only reach bytes of the current frame (count never exceeds depth)
  assign read_hit = (command == sfd_pkg::CmdRead) && ({1'b0, read_index} < count);

  // Frame store
  sfd_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (in_xfer),
    .rd_addr (read_index),
    .rd_data (store_q)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      frame_done   <= res.done;
      frame_length <= res.length;
      read_hit_q   <= read_hit;
    end
  end

  assign read_data = read_hit_q ? store_q : 8'd0;

endmodule

`default_nettype wire

/* sv/sfd_checker.sv */
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks for the SLIP frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         command,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         frame_done,
  input wire logic [sfd_pkg::CountW-1:0]   frame_length,
  input wire logic [7:0]                   read_data
);

  // A held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(frame_done)
      && $stable(frame_length) && $stable(read_data))
    else $error("result changed while stalled");

  // Every transfer yields a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  // A feed never returns read data
  a_feed_no_data: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == sfd_pkg::CmdFeed) |=> read_data == 8'd0)
    else $error("feed result carries read data");

  // A completed frame has a body and no read data
  a_done_body: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> (frame_length != '0) && (read_data == 8'd0))
    else $error("frame done with empty body or read data");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .command      (command),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .frame_done   (frame_done),
  .frame_length (frame_length),
  .read_data    (read_data)
);

`default_nettype wire

/* tb/slip_frame_decoder_tb.sv */
// ----------------------------------------------------------------------------
// slip_frame_decoder_tb
// Self-checking bench for the SLIP frame decoder. A scoreboard class tracks
// the framing state, length limit and frame body store, and predicts one
// result per accepted feed or read. Directed framing cases run first. Random
// phases follow, each with its own limit and handshake pacing, and include one
// long output stall.
// ----------------------------------------------------------------------------

module slip_frame_decoder_tb;

  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned HoldCycles = 300;

  typedef struct {
    logic                       done;
    logic [sfd_pkg::CountW-1:0] length;
    logic [7:0]                 data;
  } slip_result_t;

  // Predicts decoder results and compares them with what comes out
  class slip_board;
    logic [sfd_pkg::CountW-1:0] limit_reg;
    bit                         open_frame;
    bit                         esc_seen;
    bit                         bad_frame;
    bit                         done_hold;
    logic [sfd_pkg::CountW-1:0] count;
    logic [7:0]                 body_mem [StoreDepth];
    slip_result_t               pending_results [$];
    int                         errors;
    int                         checked;
    int                         frames_done;

    function new();
      limit_reg   = sfd_pkg::MaxLenReset;
      open_frame  = 1'b0;
      esc_seen    = 1'b0;
      bad_frame   = 1'b0;
      done_hold   = 1'b0;
      count       = '0;
      errors      = 0;
      checked     = 0;
      frames_done = 0;
    endfunction

    function void write_limit(logic [sfd_pkg::CountW-1:0] value);
      limit_reg = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // One received byte through the framing state; 1 when a frame completes
    function bit decode_feed(logic [7:0] b);
      logic [7:0]  v;
      int unsigned lim;
      v   = b;
      lim = (limit_reg > StoreDepth) ? StoreDepth : limit_reg;
      // a completed frame stays readable until the next byte arrives
      if (done_hold) begin
        done_hold = 1'b0;
        count     = '0;
      end
      if (b == sfd_pkg::SlipEnd) begin
        if (open_frame && count != 0 && !bad_frame) begin
          done_hold = 1'b1;
          esc_seen  = 1'b0;
          return 1'b1;
        end
        open_frame = 1'b1;
        count      = '0;
        esc_seen   = 1'b0;
        bad_frame  = 1'b0;
        return 1'b0;
      end
      if (!open_frame) return 1'b0;
      if (esc_seen) begin
        esc_seen = 1'b0;
        if (b == sfd_pkg::SlipEscEnd) v = sfd_pkg::SlipEnd;
        else if (b == sfd_pkg::SlipEscEsc) v = sfd_pkg::SlipEsc;
        else begin
          bad_frame = 1'b1;
          return 1'b0;
        end
      end else if (b == sfd_pkg::SlipEsc) begin
        esc_seen = 1'b1;
        return 1'b0;
      end
      // store full: byte dropped, frame marked bad
      if (count >= lim) begin
        bad_frame = 1'b1;
        return 1'b0;
      end
      body_mem[count] = v;
      count++;
      return 1'b0;
    endfunction

    function void note_item(logic cmd, logic [7:0] b, logic [sfd_pkg::IndexW-1:0] idx);
      slip_result_t r;
      r.done = 1'b0;
      r.data = '0;
      if (cmd == sfd_pkg::CmdFeed) r.done = decode_feed(b);
      else if (idx < count) r.data = body_mem[idx];
      r.length = count;
      pending_results.push_back(r);
    endfunction

    function void flag(string what, logic [sfd_pkg::CountW-1:0] want,
                       logic [sfd_pkg::CountW-1:0] got);
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(logic done, logic [sfd_pkg::CountW-1:0] len, logic [7:0] data);
      slip_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %0d/%0d/%0d",
                 $time, done, len, data);
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.done) frames_done++;
      if (done !== want.done) flag("frame_done", want.done, done);
      if (len !== want.length) flag("frame_length", want.length, len);
      if (data !== want.data) flag("read_data", want.data, data);
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic                       command;
  logic [7:0]                 rx_byte;
  logic [sfd_pkg::IndexW-1:0] read_index;
  logic                       out_valid;
  logic                       out_ready;
  logic                       frame_done;
  logic [sfd_pkg::CountW-1:0] frame_length;
  logic [7:0]                 read_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [sfd_pkg::CountW-1:0] cfg_data;

  slip_board board = new();

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int items_sent     = 0;
  int limits_used    = 0;

  slip_frame_decoder #(
    .STORE_DEPTH(StoreDepth)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .rx_byte     (rx_byte),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_done  (frame_done),
    .frame_length(frame_length),
    .read_data   (read_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Transfer monitor: config, input and result channels
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) board.write_limit(cfg_data);
      if (in_valid && in_ready) board.note_item(command, rx_byte, read_index);
      if (out_valid && out_ready) board.check_result(frame_done, frame_length, read_data);
    end
  end

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Run limit
  initial begin
    #(8 * 400000);
    $display("%0t: timeout, %0d results still outstanding", $time, board.pending());
    $display("== FAIL ==");
    $finish;
  end

  // One input transfer; valid stays high afterwards unless the caller drops it
  task automatic send_item(logic cmd, logic [7:0] b, logic [sfd_pkg::IndexW-1:0] idx);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    rx_byte    <= b;
    read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_feed(logic [7:0] b);
    send_item(sfd_pkg::CmdFeed, b, sfd_pkg::IndexW'($urandom_range(0, StoreDepth - 1)));
  endtask

  task automatic send_read(logic [sfd_pkg::IndexW-1:0] idx);
    send_item(sfd_pkg::CmdRead, 8'($urandom_range(0, 255)), idx);
  endtask

  // Mostly indexes inside the current body, sometimes anywhere
  function automatic logic [sfd_pkg::IndexW-1:0] pick_index();
    if (board.count != 0 && $urandom_range(0, 3) != 0)
      return sfd_pkg::IndexW'($urandom_range(0, board.count - 1));
    return sfd_pkg::IndexW'($urandom_range(0, StoreDepth - 1));
  endfunction

  // Body byte value, biased toward the framing codes
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       return sfd_pkg::SlipEnd;
        1:       return sfd_pkg::SlipEsc;
        2:       return sfd_pkg::SlipEscEnd;
        default: return sfd_pkg::SlipEscEsc;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // Write the limit once the block has drained
  task automatic write_limit(logic [sfd_pkg::CountW-1:0] value);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limits_used++;
  endtask

  // END, escaped body with occasional reads and faults, END
  task automatic send_frame(int unsigned body_len);
    logic [7:0]  v;
    int unsigned roll;
    send_feed(sfd_pkg::SlipEnd);
    for (int unsigned i = 0; i < body_len; i++) begin
      roll = $urandom_range(0, 199);
      if (roll < 10) send_read(pick_index());
      if (roll == 10) begin
        // bad escape
        v = 8'($urandom_range(0, 255));
        if (v == sfd_pkg::SlipEscEnd || v == sfd_pkg::SlipEscEsc) v = v - 8'd2;
        if (v == sfd_pkg::SlipEnd) v = 8'h00;
        send_feed(sfd_pkg::SlipEsc);
        send_feed(v);
      end else if (roll == 11) begin
        // escape cut short by a delimiter
        send_feed(sfd_pkg::SlipEsc);
        send_feed(sfd_pkg::SlipEnd);
      end
      v = pick_byte();
      if (v == sfd_pkg::SlipEnd) begin
        send_feed(sfd_pkg::SlipEsc);
        send_feed(sfd_pkg::SlipEscEnd);
      end else if (v == sfd_pkg::SlipEsc) begin
        send_feed(sfd_pkg::SlipEsc);
        send_feed(sfd_pkg::SlipEscEsc);
      end else begin
        send_feed(v);
      end
    end
    send_feed(sfd_pkg::SlipEnd);
  endtask

  // Body length: short, now and then past the limit
  function automatic int unsigned pick_len();
    int unsigned lim;
    int unsigned top;
    lim = (board.limit_reg > StoreDepth) ? StoreDepth : board.limit_reg;
    if ($urandom_range(0, 15) == 0) top = (lim + 2 < 40) ? lim + 2 : 40;
    else top = (lim + 1 < 10) ? lim + 1 : 10;
    if (top < 1) top = 1;
    return $urandom_range(1, top);
  endfunction

  task automatic run_phase(logic [sfd_pkg::CountW-1:0] lim, int gap_pct, int stall_pct,
                           int n_items, bit long_hold);
    int target;
    int unsigned roll;
    write_limit(lim);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    if (long_hold) hold_requests++;
    target = items_sent + n_items;
    while (items_sent < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        send_frame(pick_len());
        if ($urandom_range(0, 1) == 0) send_read(pick_index());
      end else if (roll < 80) begin
        // line noise, any byte
        repeat ($urandom_range(1, 4)) send_feed(8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        repeat ($urandom_range(1, 3)) send_read(pick_index());
      end else begin
        // broken sequences
        case ($urandom_range(0, 2))
          0: begin
            send_feed(sfd_pkg::SlipEnd);
            send_feed(sfd_pkg::SlipEnd);
          end
          1: begin
            send_feed(sfd_pkg::SlipEnd);
            send_feed(sfd_pkg::SlipEsc);
            send_feed(sfd_pkg::SlipEnd);
          end
          default: begin
            send_feed(sfd_pkg::SlipEnd);
            send_feed(8'($urandom_range(0, 255)));
            send_feed(sfd_pkg::SlipEsc);
          end
        endcase
      end
    end
  endtask

  // Main sequence
  initial begin
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    command    <= sfd_pkg::CmdFeed;
    rx_byte    <= '0;
    read_index <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit, reads on an empty store, bytes before first END
    send_read('0);
    send_read(sfd_pkg::IndexW'(StoreDepth - 1));
    send_feed(8'h41);
    send_feed(sfd_pkg::SlipEsc);
    // both escapes, extreme data values, then a good frame
    send_feed(sfd_pkg::SlipEnd);
    send_feed(8'h00);
    send_feed(8'hFF);
    send_feed(sfd_pkg::SlipEsc);
    send_feed(sfd_pkg::SlipEscEnd);
    send_feed(sfd_pkg::SlipEsc);
    send_feed(sfd_pkg::SlipEscEsc);
    send_feed(sfd_pkg::SlipEnd);
    // completed body readable, past-length read is zero
    send_read(10'd0);
    send_read(10'd3);
    send_read(10'd4);
    send_read(sfd_pkg::IndexW'(StoreDepth - 1));
    // next byte clears the length; bad escape, later bytes still stored
    send_feed(8'h55);
    send_feed(sfd_pkg::SlipEsc);
    send_feed(8'h41);
    send_feed(8'h7E);
    send_feed(sfd_pkg::SlipEnd);
    // empty frame, then END right after ESC
    send_feed(sfd_pkg::SlipEnd);
    send_feed(8'h12);
    send_feed(sfd_pkg::SlipEsc);
    send_feed(sfd_pkg::SlipEnd);

    // Limit of two: fits, then one over
    write_limit(11'd2);
    send_feed(8'h01);
    send_feed(8'h02);
    send_feed(sfd_pkg::SlipEnd);
    send_feed(8'h01);
    send_feed(8'h02);
    send_feed(8'h03);
    send_feed(sfd_pkg::SlipEnd);
    // Zero limit: every body byte is bad
    write_limit(11'd0);
    send_feed(sfd_pkg::SlipEnd);
    send_feed(8'h33);
    send_feed(sfd_pkg::SlipEnd);

    // Random phases across limits and pacing
    run_phase(11'd1024, 0,  0,  125, 1'b1);
    run_phase(11'd1,    61, 0,  125, 1'b0);
    run_phase(11'd6,    0,  61, 125, 1'b0);
    run_phase(11'd1024, 10, 10, 125, 1'b0);
    run_phase(11'd3,    0,  0,  125, 1'b0);
    run_phase(11'd2047, 61, 0,  125, 1'b0);
    run_phase(11'd12,   0,  61, 125, 1'b0);
    run_phase(11'd1025, 10, 10, 125, 1'b0);
    run_phase(11'd0,    0,  0,  125, 1'b0);

    // Drain
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items (feeds and reads), checked %0d results, %0d frames completed,",
             items_sent, board.checked, board.frames_done);
    $display("over %0d limit settings with mixed stall pacing and one long output hold.",
             limits_used);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results outstanding", board.errors, board.pending());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
sv/sfd_pkg.sv
sv/sfd_store.sv
sv/sfd_decode.sv
sv/slip_frame_decoder.sv
sv/sfd_checker.sv
tb/slip_frame_decoder_tb.sv
